/* rtl/idb_pkg.sv */
// Package for the integrator debouncer: field widths, register indexes, reset values,
// status codes and the structs passed between the core and its step logic.
// No dependencies; every other file imports this package.
package idb_pkg;

    localparam int TIME_W  = 32;
    localparam int COUNT_W = 8;
    localparam int PERIOD_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_TIMEOUT = 2'd2;

    // Register values after reset.
    localparam logic [COUNT_W-1:0]  MAX_COUNT_RST      = 8'd3;
    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST  = 16'd1;
    localparam logic [PERIOD_W-1:0] BOUNCE_TIMEOUT_RST = 16'd2000;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_WAITING  = 2'd1,
        ST_UNSTABLE = 2'd2
    } status_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  max_count;
        logic [PERIOD_W-1:0] sample_period;
        logic [PERIOD_W-1:0] bounce_timeout;
    } idb_cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               held_level;
        logic [TIME_W-1:0]  last_sample_time;
        logic [TIME_W-1:0]  last_stable_time;
    } idb_state_t;

    typedef struct packed {
        op_t               operation;
        logic              raw_level;
        logic [TIME_W-1:0] now_ms;
    } idb_item_t;

    typedef struct packed {
        logic    clean_level;
        status_t status;
    } idb_result_t;

endpackage

/* rtl/idb_if.sv */
// Valid/ready channel interfaces for the debouncer input items and results.
// Depends on idb_pkg for the field widths and the status type.
interface idb_in_if
    import idb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              operation;
    logic              raw_level;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output operation, output raw_level, output now_ms,
                    input ready);
    modport sink   (input valid, input operation, input raw_level, input now_ms,
                    output ready);
endinterface

interface idb_out_if
    import idb_pkg::*;
;
    logic    valid;
    logic    ready;
    logic    clean_level;
    status_t status;

    modport source (output valid, output clean_level, output status, input ready);
    modport sink   (input valid, input clean_level, input status, output ready);
endinterface

/* rtl/idb_step.sv */
// Combinational step of the debouncer: next state and result for one item.
// Depends on idb_pkg for the state, item, configuration and result structs.
module idb_step
    import idb_pkg::*;
(
    input  idb_cfg_t    cfg,
    input  idb_state_t  cur,
    input  idb_item_t   item,
    output idb_state_t  nxt,
    output idb_result_t res
);

    logic [TIME_W-1:0]  since_sample;
    logic [TIME_W-1:0]  since_stable;
    logic               waiting;
    logic [COUNT_W-1:0] count_step;
    logic               at_low;
    logic               at_high;

    // Elapsed times wrap modulo 2^32, which plain unsigned subtraction gives.
    assign since_sample = item.now_ms - cur.last_sample_time;
    assign since_stable = item.now_ms - cur.last_stable_time;
    assign waiting      = since_sample < {{(TIME_W-PERIOD_W){1'b0}}, cfg.sample_period};

    always_comb
    begin
        if (!item.raw_level && cur.count != '0)
        begin
            count_step = cur.count - 1'b1;
        end
        else if (item.raw_level && cur.count < cfg.max_count)
        begin
            count_step = cur.count + 1'b1;
        end
        else
        begin
            count_step = cur.count;
        end
    end

    // The low extreme wins when the maximum is zero.
    assign at_low  = count_step == '0;
    assign at_high = !at_low && count_step >= cfg.max_count;

    always_comb
    begin
        nxt = cur;
        res.clean_level = cur.held_level;
        res.status      = ST_WAITING;
        if (item.operation == OP_CLEAR)
        begin
            nxt = '0;
            res.clean_level = 1'b0;
            res.status      = ST_OK;
        end
        else if (!waiting)
        begin
            nxt.last_sample_time = item.now_ms;
            nxt.count            = count_step;
            if (at_low)
            begin
                nxt.held_level       = 1'b0;
                nxt.last_stable_time = item.now_ms;
            end
            else if (at_high)
            begin
                nxt.held_level       = 1'b1;
                nxt.last_stable_time = item.now_ms;
                nxt.count            = cfg.max_count;
            end
            res.clean_level = nxt.held_level;
            // An extreme restarts the timer, so only a zero timeout reports there.
            if (at_low || at_high)
            begin
                res.status = (cfg.bounce_timeout == '0) ? ST_UNSTABLE : ST_OK;
            end
            else
            begin
                res.status = (since_stable < {{(TIME_W-PERIOD_W){1'b0}}, cfg.bounce_timeout})
                             ? ST_OK : ST_UNSTABLE;
            end
        end
    end

endmodule

/* rtl/integrator_debouncer_with_fault_timeout_core.sv */
// Top level of the integrator switch debouncer with bounce fault timeout.
// Depends on idb_pkg, the channel interfaces in idb_if and the step logic in idb_step.
//
//  Channel   Direction  Handshake     Payload
//  in_ch     sink       valid/ready   operation, raw_level, now_ms
//  out_ch    source     valid/ready   clean_level, status
//  cfg       write      cfg_wr_en     cfg_index, cfg_data (16 bits)
//
// Every input transfer yields exactly one result, via the input and result registers.
// One item is taken in every cycle while the output is not stalled; the combinational
// step between those registers, through the debouncer state, sets that rate.
// Reset clears the valid flags, the debouncer state and restores the register defaults.
// A stalled result holds its output register; the input register still takes an item
// until it too is full, and the input side stalls only while both are occupied.
module integrator_debouncer_with_fault_timeout_core
    import idb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    idb_in_if.sink                in_ch,
    idb_out_if.source             out_ch,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    idb_cfg_t    cfg_reg;
    idb_state_t  state_reg;
    idb_state_t  state_next;
    idb_item_t   item_reg;
    logic        item_valid_reg;
    idb_result_t result_reg;
    idb_result_t result_next;
    logic        out_valid_reg;
    logic        advance;

    // The item in the input register moves on whenever the result register is free or
    // its current contents are being taken in this cycle.
    assign advance      = item_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !item_valid_reg || advance;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.clean_level = result_reg.clean_level;
    assign out_ch.status      = result_reg.status;

    // Configuration registers. Writes to an index past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_count      <= MAX_COUNT_RST;
            cfg_reg.sample_period  <= SAMPLE_PERIOD_RST;
            cfg_reg.bounce_timeout <= BOUNCE_TIMEOUT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MAX_COUNT:      cfg_reg.max_count      <= cfg_data[COUNT_W-1:0];
                REG_SAMPLE_PERIOD:  cfg_reg.sample_period  <= cfg_data[PERIOD_W-1:0];
                REG_BOUNCE_TIMEOUT: cfg_reg.bounce_timeout <= cfg_data[PERIOD_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            item_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg.operation <= op_t'(in_ch.operation);
            item_reg.raw_level <= in_ch.raw_level;
            item_reg.now_ms    <= in_ch.now_ms;
        end
    end

    idb_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    // Debouncer state and result register update together when an item advances, so
    // the following item always sees the state this one leaves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

/* rtl/idb_checker.sv */
// Port-level checks for the debouncer core, attached by the bind statement at the end.
// Depends on idb_pkg and on the top level's ports.
module idb_checker
    import idb_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input logic    out_clean_level,
    input status_t out_status
);

    logic in_xfer;

    assign in_xfer = in_valid && in_ready;

    // No result appears right after a reset.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid right after reset");

    // A consumer that takes results never holds up the input side.
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output ready");

    // A result that appears on an empty output comes from an earlier input transfer held in the input register.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_xfer, 2))
        else $error("result without a matching input transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_clean_level) && $stable(out_status))
        else $error("stalled result changed");

endmodule

bind integrator_debouncer_with_fault_timeout_core idb_checker u_idb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_clean_level (out_ch.clean_level),
    .out_status      (out_ch.status)
);
